### rtl/ise_pkg.sv
package ise_pkg;

   // Width of the element count register and of size fields
   localparam int N_W    = 3;
   localparam int SIZE_W = 3;

   // Element count after reset
   localparam logic [N_W-1:0] N_RESET = 3'd4;

endpackage

### rtl/independent_subset_enumerator.sv
// Independent subset enumerator. A request carries a packed conflict matrix
// (bit row*MAX_ELEMENTS+col) and a minimum size; the block then lists every
// subset of elements 0..n-1 of at least that size in which no two members
// conflict in either direction, by ascending size and in lexicographic order
// within a size. Each result carries the member mask and size, found=1, and
// the final result of a request carries tlast; when nothing qualifies a
// single result with found=0 is sent. One candidate combination is tested per
// cycle by the shared candidate unit while the result side keeps up; a hit
// held back by a stalled result side holds the sequence. A request tests
// every combination of the sizes from min_size to n (at most 2^n, 64 for six
// elements). The request side is not ready while a request is in work.
// The element count is sampled when a request is accepted; a count of zero
// acts as one and a count above MAX_ELEMENTS acts as MAX_ELEMENTS.
module independent_subset_enumerator import ise_pkg::*; #(
   parameter int  MAX_ELEMENTS = 6,
   localparam int REQ_W = ((MAX_ELEMENTS * MAX_ELEMENTS + SIZE_W + 7) / 8) * 8,
   localparam int RSP_W = ((MAX_ELEMENTS + SIZE_W + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   // tdata: adjacency [MAX_ELEMENTS^2 bits], min_size [3 bits], zero fill
   input  logic [REQ_W-1:0]    req_tdata,
   input  logic                req_tvalid,
   output logic                req_tready,
   // tdata: member_mask [MAX_ELEMENTS bits], subset_size [3 bits], zero fill
   output logic [RSP_W-1:0]    rsp_tdata,
   // tuser: found
   output logic                rsp_tuser,
   output logic                rsp_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic                csr_we,
   input  logic [N_W-1:0]      csr_wdata
);

   localparam int MW    = MAX_ELEMENTS;
   localparam int ADJ_W = MW * MW;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } state_type;

   state_type                state_ff, state_in;
   logic [N_W-1:0]           csr_n_ff, csr_n_in;
   logic [N_W-1:0]           n_ff, n_in;
   logic [SIZE_W-1:0]        size_ff, size_in;
   logic [MW-1:0]            code_ff, code_in;
   logic [MW-1:0][MW-1:0]    conf_ff, conf_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [MW-1:0]            pend_mask_ff, pend_mask_in;
   logic [SIZE_W-1:0]        pend_size_ff, pend_size_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0]            rsp_mask_ff, rsp_mask_in;
   logic [SIZE_W-1:0]        rsp_size_ff, rsp_size_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [ADJ_W-1:0]         req_adj;
   logic [SIZE_W-1:0]        req_min;
   logic [N_W-1:0]           n_eff;
   logic [MW-1:0]            cand_mask;
   logic                     cand_ok;
   logic [MW-1:0]            cand_next;
   logic                     out_free;
   logic                     stall;

   // Bits lo..hi-1 set
   function automatic logic [MW-1:0] range_mask(input logic [N_W-1:0] lo,
                                                 input logic [N_W-1:0] hi);
      logic [MW-1:0] m;
      m = '0;
      for (int i = 0; i < MW; i++) begin
         if (i >= int'(lo) && i < int'(hi)) begin
            m[i] = 1'b1;
         end
      end
      return m;
   endfunction

   assign req_adj = req_tdata[ADJ_W-1:0];
   assign req_min = req_tdata[ADJ_W+SIZE_W-1:ADJ_W];

   // Clamp the stored element count to 1..MAX_ELEMENTS
   always_comb begin
      n_eff = csr_n_ff;
      if (csr_n_ff == '0) begin
         n_eff = N_W'(1);
      end else if (csr_n_ff > N_W'(MW)) begin
         n_eff = N_W'(MW);
      end
   end

   // Symmetric conflict rows, diagonal and unused elements cleared
   always_comb begin
      conf_in = conf_ff;
      if (state_ff == ST_IDLE) begin
         for (int i = 0; i < MW; i++) begin
            for (int j = 0; j < MW; j++) begin
               conf_in[i][j] = (i != j) && (i < int'(n_eff)) && (j < int'(n_eff))
                               && (req_adj[i*MW+j] || req_adj[j*MW+i]);
            end
         end
      end
   end

   ise_comb_unit #(
      .MW (MW)
   ) u_unit (
      .conf        (conf_ff),
      .n_elems     (n_ff),
      .code        (code_ff),
      .member_mask (cand_mask),
      .ok          (cand_ok),
      .next_code   (cand_next)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign stall    = cand_ok && pend_valid_ff && !out_free;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      csr_n_in      = csr_n_ff;
      n_in          = n_ff;
      size_in       = size_ff;
      code_in       = code_ff;
      pend_valid_in = pend_valid_ff;
      pend_mask_in  = pend_mask_ff;
      pend_size_in  = pend_size_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_we) begin
         csr_n_in = csr_wdata;
      end

      // Drop the result once it has been transferred
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               n_in          = n_eff;
               size_in       = req_min;
               pend_valid_in = 1'b0;
               if (req_min > n_eff) begin
                  state_in = ST_FLUSH;
               end else begin
                  code_in  = range_mask('0, n_eff - req_min);
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (!stall) begin
               // Push the previous hit out, hold the new one back
               if (cand_ok) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_mask_in  = pend_mask_ff;
                     rsp_size_in  = pend_size_ff;
                     rsp_found_in = 1'b1;
                     rsp_last_in  = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_mask_in  = cand_mask;
                  pend_size_in  = size_ff;
               end
               // Advance to the next combination or the next size
               if (code_ff == range_mask(size_ff, n_ff)) begin
                  if (size_ff == n_ff) begin
                     state_in = ST_FLUSH;
                  end else begin
                     size_in = size_ff + 1'b1;
                     code_in = range_mask('0, n_ff - size_ff - 1'b1);
                  end
               end else begin
                  code_in = cand_next;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_mask_in   = pend_valid_ff ? pend_mask_ff : '0;
               rsp_size_in   = pend_valid_ff ? pend_size_ff : '0;
               rsp_found_in  = pend_valid_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         csr_n_ff      <= N_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         csr_n_ff      <= csr_n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      n_ff         <= n_in;
      size_ff      <= size_in;
      code_ff      <= code_in;
      conf_ff      <= conf_in;
      pend_mask_ff <= pend_mask_in;
      pend_size_ff <= pend_size_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_size_ff, rsp_mask_ff});
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/ise_comb_unit.sv
// Candidate unit: decodes the current combination code into a member mask,
// checks it against the conflict rows and works out the next code of the
// same size (lexicographic successor).
module ise_comb_unit import ise_pkg::*; #(
   parameter int MW = 6
) (
   input  logic [MW-1:0][MW-1:0] conf,
   input  logic [N_W-1:0]        n_elems,
   input  logic [MW-1:0]         code,
   output logic [MW-1:0]         member_mask,
   output logic                  ok,
   output logic [MW-1:0]         next_code
);

   localparam int SH_W = $clog2(MW);

   logic [MW-1:0]   inv;
   logic [MW-1:0]   low_bit;
   logic [MW-1:0]   ripple;
   logic [MW-1:0]   tail;
   logic [SH_W-1:0] shift;

   // Decode: complement within n bits, then reverse so element 0 is the top bit
   always_comb begin
      inv = '0;
      for (int i = 0; i < MW; i++) begin
         if (i < int'(n_elems)) begin
            inv[i] = ~code[i];
         end
      end
      member_mask = '0;
      for (int i = 0; i < MW; i++) begin
         for (int j = 0; j < MW; j++) begin
            if (i < int'(n_elems) && j == int'(n_elems) - 1 - i) begin
               member_mask[i] = inv[j];
            end
         end
      end
   end

   // Check every member's conflict row against the mask
   always_comb begin
      ok = 1'b1;
      for (int i = 0; i < MW; i++) begin
         if (member_mask[i] && ((conf[i] & member_mask) != '0)) begin
            ok = 1'b0;
         end
      end
   end

   // Next code with the same number of ones, next higher value
   always_comb begin
      low_bit = code & (~code + 1'b1);
      ripple  = code + low_bit;
      shift   = '0;
      for (int i = MW - 1; i >= 0; i--) begin
         if (code[i]) begin
            shift = SH_W'(i);
         end
      end
      tail      = ((ripple ^ code) >> 2) >> shift;
      next_code = tail | ripple;
   end

endmodule
